// File: rtl/afes_pkg.sv
// ----------------------------------------------------------------------------
// afes_pkg
// Shared types, constants and arithmetic helpers of the angle field energy
// stencil pipeline.
// ----------------------------------------------------------------------------
package afes_pkg;

   localparam int MAX_GRID  = 1024;
   localparam int LATENCY   = 43;
   localparam int DIV_W     = 26;

   localparam logic [10:0] GRID_RESET = 11'd65;
   localparam logic [10:0] GRID_MIN   = 11'd3;
   localparam logic [10:0] GRID_MAX   = 11'(MAX_GRID);

   localparam logic signed [16:0] PI_Q12      = 17'sd12868;
   localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

   localparam longint HQ = 64'sd421657428;
   localparam logic signed [34:0] T_OFFSET = 35'(8 * HQ + HQ / 2);

   localparam logic signed [29:0] ONE_Q28 = 30'sd268435456;
   localparam logic signed [29:0] PS0 = 30'sd740;
   localparam logic signed [29:0] PS1 = 30'sd53261;
   localparam logic signed [29:0] PS2 = 30'sd2236962;
   localparam logic signed [29:0] PS3 = 30'sd44739243;
   localparam logic signed [29:0] PC0 = 30'sd6658;
   localparam logic signed [29:0] PC1 = 30'sd372827;
   localparam logic signed [29:0] PC2 = 30'sd11184811;
   localparam logic signed [29:0] PC3 = 30'sd134217728;

   localparam logic signed [51:0] RES_MAX = 52'sd140737488355327;
   localparam logic signed [51:0] RES_MIN = -52'sd140737488355328;

   typedef struct packed {
      logic [10:0]        row;
      logic [10:0]        col;
      logic signed [15:0] center_angle;
      logic signed [15:0] next_col_angle;
      logic signed [15:0] prev_col_angle;
      logic signed [15:0] next_row_angle;
      logic signed [15:0] prev_row_angle;
   } req_type;

   typedef struct packed {
      logic signed [47:0] residual;
      logic               saturated;
   } rsp_type;

   // Operands that ride along beside the sine pipeline.
   typedef struct packed {
      logic signed [17:0] a;
      logic signed [17:0] b;
      logic signed [28:0] am;
      logic signed [28:0] bm;
      logic [9:0]         im1;
   } side_type;

   typedef struct packed {
      logic signed [28:0] x;
      logic [1:0]         quad;
      side_type           side;
   } stage_type;

   typedef struct packed {
      logic signed [29:0] s2;
      logic signed [29:0] sin2u;
      side_type           side;
   } trig_type;

   typedef struct packed {
      logic signed [51:0] sum;
      logic               keep;
   } acc_type;

   // Q28 product, rounded half up.
   function automatic logic signed [29:0] qmul(input logic signed [29:0] a,
                                               input logic signed [29:0] b);
      logic signed [59:0] p;
      p = 60'(a) * 60'(b);
      p = p + 60'sd134217728;
      return 30'(p >>> 28);
   endfunction

   function automatic logic signed [16:0] fold(input logic signed [16:0] d);
      if (d >= HALF_PI_Q12) begin
         return d - PI_Q12;
      end else if (d <= -HALF_PI_Q12) begin
         return d + PI_Q12;
      end
      return d;
   endfunction

   function automatic logic signed [34:0] quad_base(input logic [3:0] k);
      return 35'(longint'(k) * HQ);
   endfunction

   function automatic logic signed [34:0] quad_offset(input logic [3:0] k);
      return 35'(longint'(k) * HQ + HQ / 2);
   endfunction

   function automatic logic [10:0] clamp_grid(input logic [10:0] v);
      if (v < GRID_MIN) begin
         return GRID_MIN;
      end else if (v > GRID_MAX) begin
         return GRID_MAX;
      end
      return v;
   endfunction

endpackage

// File: rtl/afes_front.sv
// ----------------------------------------------------------------------------
// afes_front
// Index clamping, neighbor differences with folding, and quadrant reduction
// of the center angle. Four register stages.
// ----------------------------------------------------------------------------
module afes_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  afes_pkg::req_type   in_data,
   input  logic [10:0]         grid_n,
   output logic                out_valid,
   output afes_pkg::stage_type out_data
);

   localparam logic signed [34:0] T_OFFSET_W = afes_pkg::T_OFFSET;

   logic [9:0]  m;
   logic [10:0] i_in, j_in;

   logic               s1_vld_ff;
   logic [10:0]        s1_i_ff, s1_j_ff;
   logic signed [15:0] s1_u_ff, s1_nc_ff, s1_pc_ff, s1_nr_ff, s1_pr_ff;

   logic               first_row, last_row, first_col, last_col;
   logic signed [16:0] d_nr, d_pr, d_nc, d_pc;
   logic signed [16:0] v1_in, v2_in, v4_in, v5_in;
   logic signed [34:0] t_in;
   logic               s2_vld_ff, s2_corner_ff;
   logic signed [16:0] s2_v1_ff, s2_v2_ff, s2_v4_ff, s2_v5_ff;
   logic signed [34:0] s2_t_ff;
   logic [9:0]         s2_im1_ff;

   logic signed [16:0] f1, f2, f4, f5;
   logic [3:0]         k_in;
   logic               s3_vld_ff;
   logic signed [17:0] s3_a_ff, s3_b_ff;
   logic [3:0]         s3_k_ff;
   logic signed [34:0] s3_t_ff;
   logic [9:0]         s3_im1_ff;

   afes_pkg::stage_type s4_in, s4_ff;
   logic                s4_vld_ff;

   assign m = 10'(grid_n - 11'd1);

   always_comb begin
      i_in = in_data.row;
      if (in_data.row == 11'd0) begin
         i_in = 11'd1;
      end else if (in_data.row > grid_n) begin
         i_in = grid_n;
      end
      j_in = in_data.col;
      if (in_data.col == 11'd0) begin
         j_in = 11'd1;
      end else if (in_data.col > grid_n) begin
         j_in = grid_n;
      end
   end

   // Edge rows and columns take a one-sided difference for both halves.
   always_comb begin
      first_row = (s1_i_ff == 11'd1);
      last_row  = (s1_i_ff == grid_n);
      first_col = (s1_j_ff == 11'd1);
      last_col  = (s1_j_ff == grid_n);
      d_nr = 17'(s1_nr_ff) - 17'(s1_u_ff);
      d_pr = 17'(s1_u_ff) - 17'(s1_pr_ff);
      d_nc = 17'(s1_nc_ff) - 17'(s1_u_ff);
      d_pc = 17'(s1_u_ff) - 17'(s1_pc_ff);
      v4_in = (last_row && !first_row) ? d_pr : d_nr;
      v5_in = first_row ? d_nr : d_pr;
      v1_in = (last_col && !first_col) ? d_pc : d_nc;
      v2_in = first_col ? d_nc : d_pc;
      t_in = $signed({{3{s1_u_ff[15]}}, s1_u_ff, 16'b0}) + T_OFFSET_W;
   end

   always_comb begin
      if (s2_corner_ff) begin
         f1 = s2_v1_ff;
         f2 = s2_v2_ff;
         f4 = s2_v4_ff;
         f5 = s2_v5_ff;
      end else begin
         f1 = afes_pkg::fold(s2_v1_ff);
         f2 = afes_pkg::fold(s2_v2_ff);
         f4 = afes_pkg::fold(s2_v4_ff);
         f5 = afes_pkg::fold(s2_v5_ff);
      end
      // The offset angle always lands in quadrants three to thirteen.
      k_in = 4'd3;
      for (int kk = 4; kk <= 13; kk++) begin
         if (s2_t_ff >= afes_pkg::quad_base(4'(kk))) begin
            k_in = k_in + 4'd1;
         end
      end
   end

   always_comb begin
      s4_in.x        = 29'(s3_t_ff - afes_pkg::quad_offset(s3_k_ff));
      s4_in.quad     = s3_k_ff[1:0];
      s4_in.side.a   = s3_a_ff;
      s4_in.side.b   = s3_b_ff;
      s4_in.side.am  = 29'(s3_a_ff) * 29'($signed({1'b0, m}));
      s4_in.side.bm  = 29'(s3_b_ff) * 29'($signed({1'b0, m}));
      s4_in.side.im1 = s3_im1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_i_ff  <= i_in;
      s1_j_ff  <= j_in;
      s1_u_ff  <= in_data.center_angle;
      s1_nc_ff <= in_data.next_col_angle;
      s1_pc_ff <= in_data.prev_col_angle;
      s1_nr_ff <= in_data.next_row_angle;
      s1_pr_ff <= in_data.prev_row_angle;

      s2_v1_ff     <= v1_in;
      s2_v2_ff     <= v2_in;
      s2_v4_ff     <= v4_in;
      s2_v5_ff     <= v5_in;
      s2_corner_ff <= (first_row || last_row) && (first_col || last_col);
      s2_t_ff      <= t_in;
      s2_im1_ff    <= 10'(s1_i_ff - 11'd1);

      s3_a_ff   <= 18'(f4) + 18'(f5);
      s3_b_ff   <= 18'(f1) + 18'(f2);
      s3_k_ff   <= k_in;
      s3_t_ff   <= s2_t_ff;
      s3_im1_ff <= s2_im1_ff;

      s4_ff <= s4_in;
   end

   assign out_valid = s4_vld_ff;
   assign out_data  = s4_ff;

endmodule

// File: rtl/afes_sincos.sv
// ----------------------------------------------------------------------------
// afes_sincos
// Sine and cosine by Horner polynomials in Q28, then sin^2 and sin(2u).
// Eight register stages, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module afes_sincos (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  afes_pkg::stage_type in_data,
   output logic                out_valid,
   output afes_pkg::trig_type  out_data
);

   afes_pkg::stage_type line_ff [8];
   logic [7:0]          vld_ff;
   logic signed [29:0]  z_ff [4];
   logic signed [29:0]  ps1_ff, ps2_ff, ps3_ff, ps4_ff;
   logic signed [29:0]  pc1_ff, pc2_ff, pc3_ff, c_ff;
   logic signed [29:0]  s_ff, c10_ff, sn_ff, cs_ff, s2_ff, sin2u_ff;
   logic signed [29:0]  sn_in, cs_in;

   // Quadrant rotation of the reduced pair.
   always_comb begin
      unique case (line_ff[5].quad)
         2'd0: begin
            sn_in = s_ff;
            cs_in = c10_ff;
         end
         2'd1: begin
            sn_in = c10_ff;
            cs_in = -s_ff;
         end
         2'd2: begin
            sn_in = -s_ff;
            cs_in = -c10_ff;
         end
         default: begin
            sn_in = -c10_ff;
            cs_in = s_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      line_ff[0] <= in_data;
      for (int k = 1; k < 8; k++) begin
         line_ff[k] <= line_ff[k-1];
      end
      z_ff[0] <= afes_pkg::qmul(30'(in_data.x), 30'(in_data.x));
      for (int k = 1; k < 4; k++) begin
         z_ff[k] <= z_ff[k-1];
      end
      ps1_ff <= afes_pkg::PS1 - afes_pkg::qmul(z_ff[0], afes_pkg::PS0);
      pc1_ff <= afes_pkg::PC1 - afes_pkg::qmul(z_ff[0], afes_pkg::PC0);
      ps2_ff <= afes_pkg::PS2 - afes_pkg::qmul(z_ff[1], ps1_ff);
      pc2_ff <= afes_pkg::PC2 - afes_pkg::qmul(z_ff[1], pc1_ff);
      ps3_ff <= afes_pkg::PS3 - afes_pkg::qmul(z_ff[2], ps2_ff);
      pc3_ff <= afes_pkg::PC3 - afes_pkg::qmul(z_ff[2], pc2_ff);
      ps4_ff <= afes_pkg::ONE_Q28 - afes_pkg::qmul(z_ff[3], ps3_ff);
      c_ff   <= afes_pkg::ONE_Q28 - afes_pkg::qmul(z_ff[3], pc3_ff);
      s_ff   <= afes_pkg::qmul(30'(line_ff[4].x), ps4_ff);
      c10_ff <= c_ff;
      sn_ff  <= sn_in;
      cs_ff  <= cs_in;
      s2_ff    <= afes_pkg::qmul(sn_ff, sn_ff);
      sin2u_ff <= afes_pkg::qmul(sn_ff, cs_ff) <<< 1;
   end

   assign out_valid      = vld_ff[7];
   assign out_data.s2    = s2_ff;
   assign out_data.sin2u = sin2u_ff;
   assign out_data.side  = line_ff[7].side;

endmodule

// File: rtl/afes_div.sv
// ----------------------------------------------------------------------------
// afes_div
// Pipelined restoring divider, one quotient bit per stage, carrying the
// partial residual sum alongside.
// ----------------------------------------------------------------------------
module afes_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [afes_pkg::DIV_W-1:0]   in_num,
   input  logic [9:0]                   in_den,
   input  afes_pkg::acc_type            in_acc,
   output logic                         out_valid,
   output logic [afes_pkg::DIV_W-1:0]   out_quo,
   output afes_pkg::acc_type            out_acc
);

   localparam int W = afes_pkg::DIV_W;

   logic [W-1:0]      vld_ff;
   logic [9:0]        rem_ff [W];
   logic [W-1:0]      num_ff [W];
   logic [W-1:0]      quo_ff [W];
   logic [9:0]        den_ff [W];
   afes_pkg::acc_type acc_ff [W];

   logic [9:0]   rem_in [W];
   logic [W-1:0] num_in [W];
   logic [W-1:0] quo_in [W];
   logic [10:0]  trial  [W];
   logic [9:0]   dsr    [W];

   always_comb begin
      for (int k = 0; k < W; k++) begin
         if (k == 0) begin
            trial[k]  = {10'b0, in_num[W-1]};
            num_in[k] = in_num << 1;
            quo_in[k] = '0;
            dsr[k]    = in_den;
         end else begin
            trial[k]  = {rem_ff[k-1], num_ff[k-1][W-1]};
            num_in[k] = num_ff[k-1] << 1;
            quo_in[k] = quo_ff[k-1] << 1;
            dsr[k]    = den_ff[k-1];
         end
         rem_in[k] = trial[k][9:0];
         if (trial[k] >= {1'b0, dsr[k]}) begin
            rem_in[k]    = 10'(trial[k] - {1'b0, dsr[k]});
            quo_in[k][0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < W; k++) begin
         rem_ff[k] <= rem_in[k];
         num_ff[k] <= num_in[k];
         quo_ff[k] <= quo_in[k];
      end
      den_ff[0] <= in_den;
      acc_ff[0] <= in_acc;
      for (int k = 1; k < W; k++) begin
         den_ff[k] <= den_ff[k-1];
         acc_ff[k] <= acc_ff[k-1];
      end
   end

   assign out_valid = vld_ff[W-1];
   assign out_quo   = quo_ff[W-1];
   assign out_acc   = acc_ff[W-1];

endmodule

// File: rtl/angle_field_energy_stencil_top.sv
// ----------------------------------------------------------------------------
// angle_field_energy_stencil_top
// Nonlinear residual at one point of a square angle field.
// ----------------------------------------------------------------------------
// A transaction enters with start high while busy is low; busy stays low, so
// a new grid point can be given in every cycle. The point carries its row,
// column and the angles at the point and its four neighbors (Q4.12).
// Each point yields one residual (Q32.16, saturated with a flag) on rsp_data,
// shown for exactly one cycle with rsp_strobe high. Each result is registered
// through four front stages, eight sine stages, four product and sum stages
// and a 26-stage divider for the radial term, plus the output register.
// Throughput is one transaction per cycle, results in input order.
// The receiver has no way to stall; it must take every strobe.
// csr_we writes csr_wdata as the grid size; write it only while no
// transaction is in flight. Reset clears all valid bits and sets the grid
// size to 65.
// ----------------------------------------------------------------------------
module angle_field_energy_stencil_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  afes_pkg::req_type req_data,
   output logic              rsp_strobe,
   output afes_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [10:0]       csr_wdata
);

   logic [10:0] grid_ff, grid_n;
   logic [9:0]  m;

   logic                front_vld;
   afes_pkg::stage_type front_data;
   logic                trig_vld;
   afes_pkg::trig_type  trig_data;

   logic               s13_vld_ff;
   logic signed [58:0] s13_p2_ff, s13_p3_ff;
   logic signed [46:0] s13_aa_ff, s13_bb_ff;
   logic [37:0]        s13_nn_ff;
   logic [9:0]         s13_im1_ff;

   logic               s14_vld_ff;
   logic signed [33:0] s14_t2_ff;
   logic signed [36:0] s14_t3_ff;
   logic signed [57:0] s14_p4_ff, s14_p5_ff;
   logic [37:0]        qd_in;
   logic [25:0]        s14_qd_ff;
   logic [9:0]         s14_den_ff;
   logic               s14_keep_ff;

   logic               s15_vld_ff;
   logic signed [47:0] s15_t4_ff;
   logic signed [49:0] s15_t5_ff;
   logic signed [51:0] s15_t23_ff;
   logic [25:0]        s15_qd_ff;
   logic [9:0]         s15_den_ff;
   logic               s15_keep_ff;

   logic               s16_vld_ff;
   afes_pkg::acc_type  s16_acc_ff;
   logic [25:0]        s16_qd_ff;
   logic [9:0]         s16_den_ff;

   logic              div_vld;
   logic [25:0]       div_quo;
   afes_pkg::acc_type div_acc;

   logic signed [51:0] total;
   afes_pkg::rsp_type  rsp_in, rsp_data_ff;
   logic               rsp_strobe_ff;

   assign busy   = 1'b0;
   assign grid_n = afes_pkg::clamp_grid(grid_ff);
   assign m      = 10'(grid_n - 11'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= afes_pkg::GRID_RESET;
      end else if (csr_we) begin
         grid_ff <= csr_wdata;
      end
   end

   afes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .grid_n    (grid_n),
      .out_valid (front_vld),
      .out_data  (front_data)
   );

   afes_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_vld),
      .in_data   (front_data),
      .out_valid (trig_vld),
      .out_data  (trig_data)
   );

   // The radial term divides by (i-1)*4096; the rounding half is folded into
   // the numerator before the low twelve bits are dropped.
   assign qd_in = s13_nn_ff + {17'b0, s13_im1_ff, 11'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_vld_ff <= 1'b0;
         s14_vld_ff <= 1'b0;
         s15_vld_ff <= 1'b0;
         s16_vld_ff <= 1'b0;
      end else begin
         s13_vld_ff <= trig_vld;
         s14_vld_ff <= s13_vld_ff;
         s15_vld_ff <= s14_vld_ff;
         s16_vld_ff <= s15_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s13_p2_ff  <= 59'(trig_data.sin2u) * 59'(trig_data.side.am);
      s13_p3_ff  <= 59'(trig_data.s2) * 59'(trig_data.side.bm);
      s13_aa_ff  <= 47'(trig_data.side.a) * 47'(trig_data.side.am);
      s13_bb_ff  <= 47'(trig_data.side.b) * 47'(trig_data.side.bm);
      s13_nn_ff  <= 38'(trig_data.s2[28:0]) * 38'(m);
      s13_im1_ff <= trig_data.side.im1;

      s14_t2_ff   <= 34'((s13_p2_ff + 59'sd16777216) >>> 25);
      s14_t3_ff   <= 37'((60'sd4194304 - 60'(s13_p3_ff)) >>> 23);
      s14_p4_ff   <= 58'(s13_aa_ff) * $signed({48'b0, s13_im1_ff});
      s14_p5_ff   <= 58'(s13_bb_ff) * $signed({48'b0, s13_im1_ff});
      s14_qd_ff   <= qd_in[37:12];
      s14_den_ff  <= (s13_im1_ff == 10'd0) ? 10'd1 : s13_im1_ff;
      s14_keep_ff <= (s13_im1_ff != 10'd0);

      s15_t4_ff   <= 48'((s14_p4_ff + 58'sd512) >>> 10);
      s15_t5_ff   <= 50'((s14_p5_ff + 58'sd128) >>> 8);
      s15_t23_ff  <= 52'(s14_t2_ff) + 52'(s14_t3_ff);
      s15_qd_ff   <= s14_qd_ff;
      s15_den_ff  <= s14_den_ff;
      s15_keep_ff <= s14_keep_ff;

      s16_acc_ff.sum  <= s15_t23_ff + 52'(s15_t4_ff) + 52'(s15_t5_ff);
      s16_acc_ff.keep <= s15_keep_ff;
      s16_qd_ff       <= s15_qd_ff;
      s16_den_ff      <= s15_den_ff;
   end

   afes_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s16_vld_ff),
      .in_num    (s16_qd_ff),
      .in_den    (s16_den_ff),
      .in_acc    (s16_acc_ff),
      .out_valid (div_vld),
      .out_quo   (div_quo),
      .out_acc   (div_acc)
   );

   // On the first row the radial term is dropped.
   always_comb begin
      total = div_acc.sum;
      if (div_acc.keep) begin
         total = div_acc.sum + $signed({26'b0, div_quo});
      end
      rsp_in.saturated = 1'b0;
      rsp_in.residual  = 48'(total);
      if (total > afes_pkg::RES_MAX) begin
         rsp_in.residual  = 48'(afes_pkg::RES_MAX);
         rsp_in.saturated = 1'b1;
      end else if (total < afes_pkg::RES_MIN) begin
         rsp_in.residual  = 48'(afes_pkg::RES_MIN);
         rsp_in.saturated = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: rtl/afes_check.sv
// ----------------------------------------------------------------------------
// afes_check
// Port-level checks of the stencil top: fixed latency, saturation flag and busy held low.
// ----------------------------------------------------------------------------
module afes_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input afes_pkg::rsp_type rsp_data
);

   // Every accepted transaction shows its result after the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(afes_pkg::LATENCY) rsp_strobe)
      else $error("result missing after fixed latency");

   // No result appears without a transaction accepted at the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, afes_pkg::LATENCY))
      else $error("result without matching transaction");

   // A clipped residual sits at one of the range limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.saturated) |->
         (rsp_data.residual == 48'sh7FFFFFFFFFFF ||
          rsp_data.residual == 48'sh800000000000))
      else $error("saturation flag without clipped value");

   // The block never holds off a transaction.
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

bind angle_field_energy_stencil_top afes_check u_afes_check (.*);
